### hw/rtl/spsg_pkg.sv
// ----------------------------------------------------------------------------
// spsg_pkg
// shared types and constants of the servo pwm sweep generator
// ----------------------------------------------------------------------------
package spsg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ADC_W      = 12;
  localparam int ANGLE_W    = 8;
  localparam int PULSE_W    = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [7:0]  FULL_ANGLE  = 8'd180;
  localparam logic [15:0] RESET_PULSE = 16'd500;

  // reset values of the registers
  localparam logic        RST_MODE     = 1'b0;
  localparam logic [15:0] RST_MIN      = 16'd500;
  localparam logic [15:0] RST_MAX      = 16'd2500;
  localparam logic [15:0] RST_PERIOD   = 16'd20000;
  localparam logic [7:0]  RST_ANG_LOW  = 8'd0;
  localparam logic [7:0]  RST_ANG_HIGH = 8'd180;
  localparam logic [7:0]  RST_STEP     = 8'd1;
  localparam logic [7:0]  RST_PPS      = 8'd1;

  // divide by 180 as multiply by reciprocal, exact for products below 2**24
  localparam int          D180_N_W = 24;
  localparam int          D180_S   = 32;
  localparam int          D180_M_W = 25;
  localparam logic [D180_M_W-1:0] D180_M =
    D180_M_W'(((64'd1 << D180_S) / 64'd180) + 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_MIN_PULSE = 3'd1,
    REG_MAX_PULSE = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_ANG_LOW   = 3'd4,
    REG_ANG_HIGH  = 3'd5,
    REG_STEP      = 3'd6,
    REG_PPS       = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ANGLE,
    ST_PMUL,
    ST_PDIV,
    ST_PULSE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic angle;
    logic pmul;
    logic pdiv;
    logic pulse;
    logic load_out;
  } cmd_t;

endpackage

### hw/rtl/spsg_ctrl.sv
// ----------------------------------------------------------------------------
// spsg_ctrl
// sequencer: walks one tick through the datapath steps and owns out_tvalid
// ----------------------------------------------------------------------------
module spsg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output spsg_pkg::cmd_t cmd
);
  import spsg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_ANGLE;
      ST_ANGLE: state_nxt = ST_PMUL;
      ST_PMUL:  state_nxt = ST_PDIV;
      ST_PDIV:  state_nxt = ST_PULSE;
      ST_PULSE: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:  cmd.capture  = in_tvalid;
      ST_MUL1:  cmd.mul1     = 1'b1;
      ST_MUL2:  cmd.mul2     = 1'b1;
      ST_ANGLE: cmd.angle    = 1'b1;
      ST_PMUL:  cmd.pmul     = 1'b1;
      ST_PDIV:  cmd.pdiv     = 1'b1;
      ST_PULSE: cmd.pulse    = 1'b1;
      ST_OUT:   cmd.load_out = out_free;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/spsg_dpath.sv
// ----------------------------------------------------------------------------
// spsg_dpath
// registers, tick timer, angle mapping, sweep and pulse width arithmetic
// ----------------------------------------------------------------------------
module spsg_dpath #(
  parameter int ADC_FULL_SCALE = 4095,
  parameter int TIMER_WIDTH    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spsg_pkg::cmd_t                      cmd,
  input  logic                                cfg_we,
  input  logic [spsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spsg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [spsg_pkg::ADC_W-1:0]          adc_sample,
  input  logic                                sample_valid,
  output logic                                pwm_level,
  output logic                                period_start,
  output logic [spsg_pkg::ANGLE_W-1:0]        current_angle,
  output logic [spsg_pkg::PULSE_W-1:0]        pulse_width_us
);
  import spsg_pkg::*;

  // adc scaling: divide by full scale as multiply by reciprocal
  localparam int ADC_N_W = 20;
  localparam int ADC_M_W = 22;
  localparam int ADC_P_W = ADC_N_W + ADC_M_W;
  localparam int ADC_S   = ADC_N_W + $clog2(ADC_FULL_SCALE);
  localparam logic [ADC_M_W-1:0] ADC_M =
    ADC_M_W'(((64'd1 << ADC_S) / 64'(ADC_FULL_SCALE)) + 64'd1);
  localparam int D180_P_W = D180_N_W + D180_M_W;
  localparam int Q2_W     = D180_P_W - D180_S;
  localparam int CW       = ((TIMER_WIDTH > PULSE_W) ? TIMER_WIDTH : PULSE_W) + 1;

  // configuration
  logic        mode_r;
  logic [15:0] min_r, max_r, period_r;
  logic [7:0]  ang_low_r, ang_high_r, step_r, pps_r;

  // state
  logic [TIMER_WIDTH-1:0] tick_r;
  logic [PULSE_W-1:0]     pulse_r;
  logic [ANGLE_W-1:0]     angle_r;
  logic                   sweep_up_r;
  logic [7:0]             pcount_r;
  logic                   pin_r;

  // per-tick working registers
  logic [ADC_W-1:0]       adc_r;
  logic                   manual_r, start_r, upd_r;
  logic [ADC_N_W-1:0]     n_r;
  logic [ADC_P_W-1:0]     adcq_r;
  logic [D180_N_W-1:0]    prod_r;
  logic [D180_P_W-1:0]    pq_r;

  // output payload
  logic                   o_pin_r, o_start_r;
  logic [ANGLE_W-1:0]     o_angle_r;
  logic [PULSE_W-1:0]     o_pulse_r;

  // angle step
  logic [15:0]  q16, a1;
  logic [7:0]   man_ang;
  logic [7:0]   pc_inc;
  logic         do_sweep;
  logic signed [9:0] nxt_s, hi_s, lo_s;
  logic [7:0]   sw_ang;
  logic         sw_up;

  // pulse step
  logic [15:0]  diff;
  logic [Q2_W-1:0] q2;
  logic [17:0]  sum;
  logic [15:0]  pw_map, pw_new;
  logic [15:0]  period_eff;
  logic [CW-1:0] tick_inc;

  always_comb begin
    q16     = 16'(adcq_r[ADC_P_W-1:ADC_S]);
    a1      = (q16 > {8'd0, ang_high_r}) ? {8'd0, ang_high_r} : q16;
    man_ang = (a1 < {8'd0, ang_low_r}) ? ang_low_r : a1[7:0];

    pc_inc   = (pcount_r < 8'd255) ? pcount_r + 8'd1 : pcount_r;
    do_sweep = start_r && mode_r && (pc_inc >= pps_r);

    hi_s  = signed'({2'b00, ang_high_r});
    lo_s  = signed'({2'b00, ang_low_r});
    nxt_s = sweep_up_r ? signed'({2'b00, angle_r}) + signed'({2'b00, step_r})
                       : signed'({2'b00, angle_r}) - signed'({2'b00, step_r});
    sw_up  = sweep_up_r;
    sw_ang = nxt_s[7:0];
    if (nxt_s >= hi_s) begin
      sw_ang = ang_high_r;
      sw_up  = 1'b0;
    end else if (nxt_s <= lo_s) begin
      sw_ang = ang_low_r;
      sw_up  = 1'b1;
    end
  end

  always_comb begin
    diff = (max_r >= min_r) ? max_r - min_r : min_r - max_r;
    q2   = pq_r[D180_P_W-1:D180_S];
    sum  = 18'(min_r) + 18'(q2);
    if (max_r >= min_r) begin
      pw_map = (sum > 18'd65535) ? 16'hffff : sum[15:0];
    end else begin
      pw_map = (18'(q2) >= 18'(min_r)) ? 16'd0 : min_r - q2[15:0];
    end
    pw_new     = upd_r ? pw_map : pulse_r;
    period_eff = (period_r == 16'd0) ? 16'd1 : period_r;
    tick_inc   = CW'(tick_r) + CW'(1);
  end

  // configuration and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= RST_MODE;
      min_r      <= RST_MIN;
      max_r      <= RST_MAX;
      period_r   <= RST_PERIOD;
      ang_low_r  <= RST_ANG_LOW;
      ang_high_r <= RST_ANG_HIGH;
      step_r     <= RST_STEP;
      pps_r      <= RST_PPS;
      tick_r     <= '0;
      pulse_r    <= RESET_PULSE;
      angle_r    <= '0;
      sweep_up_r <= 1'b1;
      pcount_r   <= '0;
      pin_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MODE: begin
            mode_r     <= cfg_data[0];
            sweep_up_r <= 1'b1;
          end
          REG_MIN_PULSE: min_r      <= cfg_data;
          REG_MAX_PULSE: max_r      <= cfg_data;
          REG_PERIOD:    period_r   <= cfg_data;
          REG_ANG_LOW:   ang_low_r  <= cfg_data[7:0];
          REG_ANG_HIGH:  ang_high_r <= cfg_data[7:0];
          REG_STEP:      step_r     <= cfg_data[7:0];
          REG_PPS:       pps_r      <= cfg_data[7:0];
        endcase
      end
      if (cmd.angle) begin
        if (manual_r) begin
          angle_r <= man_ang;
        end
        if (start_r) begin
          pcount_r <= pc_inc;
        end
        if (do_sweep) begin
          pcount_r   <= '0;
          angle_r    <= sw_ang;
          sweep_up_r <= sw_up;
        end
      end
      if (cmd.pulse) begin
        pulse_r <= pw_new;
        pin_r   <= (CW'(tick_r) < CW'(pw_new));
        if (tick_inc >= CW'(period_eff)) tick_r <= '0;
        else tick_r <= tick_inc[TIMER_WIDTH-1:0];
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      adc_r    <= adc_sample;
      manual_r <= sample_valid && !mode_r;
      start_r  <= (tick_r == '0);
    end
    if (cmd.mul1) n_r <= ADC_N_W'(adc_r) * ADC_N_W'(FULL_ANGLE);
    if (cmd.mul2) adcq_r <= ADC_P_W'(n_r) * ADC_P_W'(ADC_M);
    if (cmd.angle) upd_r <= manual_r || do_sweep;
    if (cmd.pmul) prod_r <= D180_N_W'(angle_r) * D180_N_W'(diff);
    if (cmd.pdiv) pq_r <= D180_P_W'(prod_r) * D180_P_W'(D180_M);
    if (cmd.load_out) begin
      o_pin_r   <= pin_r;
      o_start_r <= start_r;
      o_angle_r <= angle_r;
      o_pulse_r <= pulse_r;
    end
  end

  assign pwm_level      = o_pin_r;
  assign period_start   = o_start_r;
  assign current_angle  = o_angle_r;
  assign pulse_width_us = o_pulse_r;

endmodule

### hw/rtl/servo_pwm_sweep_generator.sv
// ----------------------------------------------------------------------------
// servo_pwm_sweep_generator
// hobby servo pwm generator with adc follow and automatic sweep modes
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata adc_sample, tuser sample_valid
//   out_    | out | out_tvalid/tready  | tdata pwm_level, angle, pulse width
//   cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// one beat per microsecond tick; a beat is accepted only in the idle state, and
// the step sequencer walks it through two multiplier stages for the adc
// mapping and two for the pulse mapping before the next accept.
// the result register lets the next beat be worked on while one waits.
// synchronous active-low reset restores register defaults and state.
// ----------------------------------------------------------------------------
module servo_pwm_sweep_generator #(
  parameter int ADC_FULL_SCALE = 4095,
  parameter int TIMER_WIDTH    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spsg_pkg::IN_DATA_W-1:0]      in_tdata,   // [11:0] adc_sample
  input  logic                                in_tuser,   // [0] sample_valid
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spsg_pkg::OUT_DATA_W-1:0]     out_tdata,  // [0] pwm_level,
                                                          // [8:1] current_angle,
                                                          // [24:9] pulse_width_us
  output logic                                out_tuser,  // [0] period_start
  input  logic                                cfg_we,
  input  logic [spsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import spsg_pkg::*;

  cmd_t               cmd;
  logic               pwm_level;
  logic               period_start;
  logic [ANGLE_W-1:0] current_angle;
  logic [PULSE_W-1:0] pulse_width_us;

  spsg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spsg_dpath #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE),
    .TIMER_WIDTH    (TIMER_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .adc_sample     (in_tdata[ADC_W-1:0]),
    .sample_valid   (in_tuser),
    .pwm_level      (pwm_level),
    .period_start   (period_start),
    .current_angle  (current_angle),
    .pulse_width_us (pulse_width_us)
  );

  assign out_tdata = {7'd0, pulse_width_us, current_angle, pwm_level};
  assign out_tuser = period_start;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// servo pwm sweep generator testbench
// drives microsecond ticks with and without adc samples through a series of
// register settings in follow and sweep modes, predicts every result beat
// from a behavioural model of the pwm counter, angle mapping and sweep, and
// compares each accepted result field by field under varying back-pressure
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spsg_pkg::*;

  localparam int ADC_FULL    = 4095;
  localparam int SETTLE      = 12;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM    = 14;
  localparam int PHASE_BEATS = 54;

  typedef struct {
    logic        mode;
    logic [15:0] min_p;
    logic [15:0] max_p;
    logic [15:0] period;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  step;
    logic [7:0]  pps;
  } servo_cfg_t;

  typedef struct packed {
    logic        pwm;
    logic        start;
    logic [7:0]  angle;
    logic [15:0] pulse;
  } tick_result_t;

  class pwm_tick_board;
    logic        mode;
    int unsigned min_p, max_p, period, lo, hi, step, pps;
    int unsigned tick_count, pulse_width, angle, period_count;
    logic        sweep_up;
    tick_result_t pending_ticks[$];
    int failures;
    int ticks_seen;
    int starts_seen;
    int sweep_ticks;

    function new();
      mode = RST_MODE;
      min_p = RST_MIN;
      max_p = RST_MAX;
      period = RST_PERIOD;
      lo = RST_ANG_LOW;
      hi = RST_ANG_HIGH;
      step = RST_STEP;
      pps = RST_PPS;
      tick_count = 0;
      pulse_width = RESET_PULSE;
      angle = 0;
      sweep_up = 1'b1;
      period_count = 0;
      failures = 0;
      ticks_seen = 0;
      starts_seen = 0;
      sweep_ticks = 0;
    endfunction

    function void apply_reg(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        REG_MODE: begin
          mode = v[0];
          sweep_up = 1'b1;
        end
        REG_MIN_PULSE: min_p = v;
        REG_MAX_PULSE: max_p = v;
        REG_PERIOD:    period = v;
        REG_ANG_LOW:   lo = v[7:0];
        REG_ANG_HIGH:  hi = v[7:0];
        REG_STEP:      step = v[7:0];
        REG_PPS:       pps = v[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned angle_to_pulse(int unsigned ang);
      int unsigned p;
      int unsigned d;
      if (max_p >= min_p) begin
        p = min_p + (ang * (max_p - min_p)) / int'(FULL_ANGLE);
        if (p > 65535) p = 65535;
      end else begin
        d = (ang * (min_p - max_p)) / int'(FULL_ANGLE);
        p = (d >= min_p) ? 0 : min_p - d;
      end
      return p;
    endfunction

    function void follow_sample(int unsigned ang);
      if (ang > hi) ang = hi;
      if (ang < lo) ang = lo;
      angle = ang & 8'hFF;
      pulse_width = angle_to_pulse(angle);
    endfunction

    function void sweep_once();
      int nxt;
      nxt = int'(angle);
      period_count = 0;
      if (sweep_up) nxt = nxt + int'(step);
      else nxt = nxt - int'(step);
      if (nxt >= int'(hi)) begin
        nxt = int'(hi);
        sweep_up = 1'b0;
      end else if (nxt <= int'(lo)) begin
        nxt = int'(lo);
        sweep_up = 1'b1;
      end
      angle = nxt & 8'hFF;
      pulse_width = angle_to_pulse(angle);
    endfunction

    function void note_tick(logic [11:0] adc, logic valid);
      tick_result_t r;
      int unsigned len;
      len = (period == 0) ? 1 : period;
      r.start = 1'b0;
      if (valid && mode == 1'b0)
        follow_sample((int'(adc) * int'(FULL_ANGLE)) / ADC_FULL);
      if (tick_count == 0) begin
        r.start = 1'b1;
        if (period_count < 255) period_count++;
        if (mode == 1'b1 && period_count >= pps) sweep_once();
      end
      r.pwm = (tick_count < pulse_width);
      if (tick_count + 1 >= len) tick_count = 0;
      else tick_count = (tick_count + 1) & 16'hFFFF;
      r.angle = angle[7:0];
      r.pulse = pulse_width[15:0];
      if (mode) sweep_ticks++;
      pending_ticks.push_back(r);
    endfunction

    function void check_out_beat(logic [OUT_DATA_W-1:0] tdata, logic tuser);
      tick_result_t e;
      if (pending_ticks.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result beat with nothing expected: tdata=%h tuser=%b", tdata, tuser);
        return;
      end
      e = pending_ticks.pop_front();
      ticks_seen++;
      if (e.start) starts_seen++;
      if (tdata[0] !== e.pwm || tuser !== e.start || tdata[8:1] !== e.angle ||
          tdata[24:9] !== e.pulse) begin
        failures++;
        if (failures <= 10)
          $display({"tick %0d: expected pwm=%b start=%b angle=%0d pulse=%0d, ",
                    "got pwm=%b start=%b angle=%0d pulse=%0d"},
                   ticks_seen, e.pwm, e.start, e.angle, e.pulse,
                   tdata[0], tuser, tdata[8:1], tdata[24:9]);
      end
    endfunction

    function int pending();
      return pending_ticks.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pwm_tick_board sb;
  int send_idle_pct;
  int stall_pct;
  int settings_used;
  int quiet_cycles;

  servo_pwm_sweep_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side with random back-pressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_out_beat(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic set_idling(int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 67; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 67; end
      default: begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  task automatic send_beat(logic [11:0] adc, logic valid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, adc};
    in_tuser  <= valid;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(adc, valid);
  endtask

  task automatic end_phase();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.apply_reg(idx, v);
  endtask

  task automatic load_settings(servo_cfg_t c);
    write_reg(REG_MODE, {15'b0, c.mode});
    write_reg(REG_MIN_PULSE, c.min_p);
    write_reg(REG_MAX_PULSE, c.max_p);
    write_reg(REG_PERIOD, c.period);
    write_reg(REG_ANG_LOW, {8'b0, c.lo});
    write_reg(REG_ANG_HIGH, {8'b0, c.hi});
    write_reg(REG_STEP, {8'b0, c.step});
    write_reg(REG_PPS, {8'b0, c.pps});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic servo_cfg_t random_settings();
    servo_cfg_t c;
    c.mode = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: c.period = 16'd0;
      1: c.period = 16'hFFFF;
      2: c.period = 16'($urandom_range(200, 1));
      default: c.period = 16'($urandom_range(24, 1));
    endcase
    case ($urandom_range(4))
      0: begin
        c.min_p = 16'($urandom_range(65535));
        c.max_p = 16'($urandom_range(65535));
      end
      1: begin
        c.max_p = 16'($urandom_range(10));
        c.min_p = 16'(c.max_p + $urandom_range(30));
      end
      default: begin
        c.min_p = 16'($urandom_range(10));
        c.max_p = 16'(c.min_p + $urandom_range(30));
      end
    endcase
    if ($urandom_range(4) == 0) begin
      c.hi = 8'($urandom_range(170));
      c.lo = 8'($urandom_range(180, c.hi + 1));
    end else begin
      c.lo = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(90));
      c.hi = ($urandom_range(3) == 0) ? 8'd180 : 8'($urandom_range(180, c.lo));
    end
    case ($urandom_range(5))
      0: c.step = 8'd0;
      1: c.step = 8'd180;
      default: c.step = 8'($urandom_range(40, 1));
    endcase
    case ($urandom_range(5))
      0: c.pps = 8'd0;
      1: c.pps = 8'd255;
      default: c.pps = 8'($urandom_range(3, 1));
    endcase
    return c;
  endfunction

  initial begin
    logic [11:0] adc;
    sb = new();
    send_idle_pct = 0;
    stall_pct = 0;
    settings_used = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, adc extremes and a tick without a sample
    send_beat(12'h000, 1'b1);
    send_beat(12'hFFF, 1'b1);
    send_beat(12'h000, 1'b0);
    send_beat(12'h800, 1'b1);
    end_phase();

    // full pulse range, short period
    set_idling(1);
    load_settings('{1'b0, 16'd0, 16'hFFFF, 16'd8, 8'd0, 8'd180, 8'd1, 8'd1});
    send_beat(12'hFFF, 1'b1);
    send_beat(12'h001, 1'b1);
    send_beat(12'hFFE, 1'b1);
    send_beat(12'h7FF, 1'b0);
    end_phase();

    // crossed angle limits
    set_idling(2);
    load_settings('{1'b0, 16'd10, 16'd200, 16'd5, 8'd150, 8'd20, 8'd1, 8'd1});
    send_beat(12'hFFF, 1'b1);
    send_beat(12'h000, 1'b1);
    end_phase();

    // reversed pulse range down to zero pulse and up to long pulse
    set_idling(3);
    load_settings('{1'b0, 16'hFFFF, 16'd0, 16'd4, 8'd0, 8'd180, 8'd1, 8'd1});
    send_beat(12'hFFF, 1'b1);
    send_beat(12'h000, 1'b1);
    send_beat(12'h800, 1'b1);
    end_phase();

    // zero period, sweep on every start, overshooting steps, samples ignored
    set_idling(0);
    load_settings('{1'b1, 16'd3, 16'd40, 16'd0, 8'd10, 8'd170, 8'd180, 8'd0});
    send_beat(12'hFFF, 1'b1);
    send_beat(12'h000, 1'b1);
    send_beat(12'hABC, 1'b1);
    send_beat(12'h543, 1'b0);
    end_phase();

    // long period then a shorter one while the counter is past it
    load_settings('{1'b0, 16'd2, 16'd6, 16'd40, 8'd0, 8'd180, 8'd1, 8'd1});
    repeat (6) send_beat(12'($urandom_range(4095)), 1'b1);
    end_phase();
    load_settings('{1'b0, 16'd2, 16'd6, 16'd3, 8'd0, 8'd180, 8'd1, 8'd1});
    repeat (4) send_beat(12'($urandom_range(4095)), 1'b1);
    end_phase();

    for (int ph = 0; ph < N_RANDOM; ph++) begin
      set_idling(ph);
      load_settings(random_settings());
      repeat (PHASE_BEATS) begin
        case ($urandom_range(15))
          0: adc = 12'h000;
          1: adc = 12'hFFF;
          default: adc = 12'($urandom_range(4095));
        endcase
        send_beat(adc, $urandom_range(3) != 0);
      end
      end_phase();
    end

    $display("covered %0d ticks, %0d period starts, over %0d register settings",
             sb.ticks_seen, sb.starts_seen, settings_used);
    $display("%0d ticks ran in sweep mode, the rest followed the adc", sb.sweep_ticks);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.failures, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/spsg_pkg.sv
hw/rtl/spsg_ctrl.sv
hw/rtl/spsg_dpath.sv
hw/rtl/servo_pwm_sweep_generator.sv
verif/testbench.sv
